### hw/rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token kinds, character codes and keyword table for the lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int KEYWORD_CHARS_DEF = 6;
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int NUM_KEYWORDS      = 18;

  // lexer modes, one-hot
  typedef enum logic [18:0] {
    M_IDLE    = 19'h00001,
    M_COMMENT = 19'h00002,
    M_IDENT   = 19'h00004,
    M_NUM_INT = 19'h00008,
    M_NUM_DOT = 19'h00010,
    M_NUM_FRAC= 19'h00020,
    M_STR_DQ  = 19'h00040,
    M_STR_SQ  = 19'h00080,
    M_AT      = 19'h00100,
    M_IMPL    = 19'h00200,
    M_DOT     = 19'h00400,
    M_PROP    = 19'h00800,
    M_COLON   = 19'h01000,
    M_MSG     = 19'h02000,
    M_MSG_SFX = 19'h04000,
    M_MINUS   = 19'h08000,
    M_EQUAL   = 19'h10000,
    M_LESS    = 19'h20000,
    M_GREATER = 19'h40000
  } mode_t;

  // token kinds
  localparam logic [5:0] K_IDENT           = 6'd18;
  localparam logic [5:0] K_STRING          = 6'd19;
  localparam logic [5:0] K_INTERP          = 6'd20;
  localparam logic [5:0] K_INTERP_END      = 6'd21;
  localparam logic [5:0] K_NUMBER          = 6'd22;
  localparam logic [5:0] K_IMPLICIT        = 6'd23;
  localparam logic [5:0] K_PROPERTY        = 6'd24;
  localparam logic [5:0] K_MESSAGE         = 6'd25;
  localparam logic [5:0] K_NEWLINE         = 6'd26;
  localparam logic [5:0] K_PLUS            = 6'd27;
  localparam logic [5:0] K_MINUS           = 6'd28;
  localparam logic [5:0] K_STAR            = 6'd29;
  localparam logic [5:0] K_SLASH           = 6'd30;
  localparam logic [5:0] K_PERCENT         = 6'd31;
  localparam logic [5:0] K_LBRACKET        = 6'd32;
  localparam logic [5:0] K_RBRACKET        = 6'd33;
  localparam logic [5:0] K_LPAREN          = 6'd34;
  localparam logic [5:0] K_RPAREN          = 6'd35;
  localparam logic [5:0] K_LBRACE          = 6'd36;
  localparam logic [5:0] K_RBRACE          = 6'd37;
  localparam logic [5:0] K_COMMA           = 6'd38;
  localparam logic [5:0] K_PIPE            = 6'd39;
  localparam logic [5:0] K_QUESTION        = 6'd40;
  localparam logic [5:0] K_AMPER           = 6'd41;
  localparam logic [5:0] K_BANG            = 6'd42;
  localparam logic [5:0] K_AT              = 6'd43;
  localparam logic [5:0] K_DOT             = 6'd44;
  localparam logic [5:0] K_DOTDOT          = 6'd45;
  localparam logic [5:0] K_ARROW           = 6'd46;
  localparam logic [5:0] K_COLON           = 6'd47;
  localparam logic [5:0] K_COLON_EQ        = 6'd48;
  localparam logic [5:0] K_EQUAL           = 6'd49;
  localparam logic [5:0] K_EQ_EQ           = 6'd50;
  localparam logic [5:0] K_FAT_ARROW       = 6'd51;
  localparam logic [5:0] K_LESS            = 6'd52;
  localparam logic [5:0] K_LESS_EQ         = 6'd53;
  localparam logic [5:0] K_LESS_LESS       = 6'd54;
  localparam logic [5:0] K_GREATER         = 6'd55;
  localparam logic [5:0] K_GREATER_EQ      = 6'd56;
  localparam logic [5:0] K_GREATER_GREATER = 6'd57;
  localparam logic [5:0] K_EOF             = 6'd58;
  localparam logic [5:0] K_ERROR           = 6'd59;

  // error codes
  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_STRING = 2'd1;
  localparam logic [1:0] E_TOKEN  = 2'd2;

  // character codes
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  // keyword text, first character in the low byte, zero padded
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    64'h646e61, 64'h6f64, 64'h666564, 64'h65736c65, 64'h646e65,
    64'h65736c6166, 64'h686374616d, 64'h726f66, 64'h6e656874, 64'h6e69,
    64'h746f6e, 64'h726f, 64'h6e7275746572, 64'h646c656979, 64'h65757274,
    64'h6c696e, 64'h706f6f6c, 64'h6c69746e75
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd3, 4'd2, 4'd3, 4'd4, 4'd3, 4'd5, 4'd5, 4'd3, 4'd4,
    4'd2, 4'd3, 4'd2, 4'd6, 4'd5, 4'd4, 4'd3, 4'd4, 4'd5
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] len;
    logic [31:0] line;
    logic [1:0]  err;
  } tok_t;

  // all tokens closed by one source byte
  typedef struct packed {
    logic [1:0]       cnt;
    tok_t [2:0]       tok;
  } run_t;

  function automatic logic [5:0] kw_kind(input logic [63:0] text, input logic [3:0] len);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      if (len == KW_LEN[i] && text == KW_TEXT[i]) k = 6'(i);
    end
    return k;
  endfunction

endpackage

### hw/rtl/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front
// Lexer state and byte classification; closes up to three tokens per byte.
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] src_byte,
  input  logic       q_full,
  output logic       push,
  output run_t       push_run
);

  localparam int KB = 8 * KEYWORD_CHARS;

  logic [7:0]             comment_char;
  mode_t                  lex_mode, lex_mode_next;
  logic [7:0]             curly_depth, curly_depth_next;
  logic [31:0]            row_count, row_count_next;
  logic [LENGTH_BITS-1:0] token_len, token_len_next;
  logic [KB-1:0]          keyword_buffer, keyword_buffer_next;
  logic                   brace_str, brace_str_next;
  run_t                   run;

  logic accept;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (run.cnt != 2'd0);
  assign push_run = run;

  always_comb begin
    logic [7:0] c;
    logic alpha, digit, blank, endc, sfx, word;
    logic again, ev, post_dot, post_restart;
    logic [5:0] ek;
    logic [1:0] ee;
    logic [3:0] klen;

    c     = src_byte;
    alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    digit = c >= 8'h30 && c <= 8'h39;
    blank = c == CH_SPACE || c == CH_TAB || c == CH_CR;
    endc  = c == 8'h00 || c == 8'hff;
    sfx   = c == CH_QMARK || c == CH_BANG;
    word  = alpha || digit;

    lex_mode_next       = lex_mode;
    curly_depth_next    = curly_depth;
    row_count_next      = row_count;
    token_len_next      = token_len;
    keyword_buffer_next = keyword_buffer;
    brace_str_next      = brace_str;
    run                 = '0;
    again               = 1'b1;

    for (int i = 0; i < 4; i++) begin
      ev = 1'b0; ek = K_ERROR; ee = E_NONE; post_dot = 1'b0; post_restart = 1'b0;
      klen = (token_len_next > LENGTH_BITS'(15)) ? 4'd15 : 4'(token_len_next);
      if (again) begin
        again = 1'b0;
        unique case (lex_mode_next)
          M_COMMENT: begin
            if (endc) begin
              lex_mode_next = M_IDLE;
              again = 1'b1;
            end else if (c == CH_LF) begin
              lex_mode_next = M_IDLE;
            end
          end
          M_IDENT: begin
            if (word) begin
              for (int j = 0; j < KEYWORD_CHARS; j++) begin
                if (token_len_next == LENGTH_BITS'(j)) keyword_buffer_next[8*j +: 8] = c;
              end
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
            end else if (sfx) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              ev = 1'b1; ek = K_IDENT;
            end else begin
              ev = 1'b1; ek = kw_kind(64'(keyword_buffer_next), klen); again = 1'b1;
            end
          end
          M_NUM_INT: begin
            if (digit) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
            end else if (c == CH_DOT) begin
              lex_mode_next = M_NUM_DOT;
            end else begin
              ev = 1'b1; ek = K_NUMBER; again = 1'b1;
            end
          end
          M_NUM_DOT: begin
            if (digit) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              lex_mode_next = M_NUM_FRAC;
            end else begin
              // number ends before the dot, which starts its own token
              ev = 1'b1; ek = K_NUMBER; post_dot = 1'b1; again = 1'b1;
            end
          end
          M_NUM_FRAC, M_IMPL: begin
            if (digit) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
            end else begin
              ev = 1'b1; ek = (lex_mode_next == M_IMPL) ? K_IMPLICIT : K_NUMBER;
              again = 1'b1;
            end
          end
          M_STR_DQ: begin
            if (endc) begin
              ev = 1'b1; ek = K_ERROR; ee = E_STRING; again = 1'b1;
            end else begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              if (c == CH_DQUOTE) begin ev = 1'b1; ek = K_STRING; end
            end
          end
          M_STR_SQ: begin
            if (endc || c == CH_LF) begin
              ev = 1'b1; ek = K_ERROR; ee = E_STRING; again = 1'b1;
            end else begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              if (c == CH_LBRACE) begin
                if (curly_depth_next != 8'hff) curly_depth_next = curly_depth_next + 8'd1;
                ev = 1'b1; ek = K_INTERP;
              end else if (c == CH_SQUOTE) begin
                ev = 1'b1; ek = brace_str_next ? K_INTERP_END : K_STRING;
              end
            end
          end
          M_AT: begin
            if (digit) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              lex_mode_next = M_IMPL;
            end else begin
              ev = 1'b1; ek = K_AT; again = 1'b1;
            end
          end
          M_DOT: begin
            if (alpha) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              lex_mode_next = M_PROP;
            end else if (c == CH_DOT) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              ev = 1'b1; ek = K_DOTDOT;
            end else begin
              ev = 1'b1; ek = K_DOT; again = 1'b1;
            end
          end
          M_PROP: begin
            if (word || sfx) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              if (sfx) begin ev = 1'b1; ek = K_PROPERTY; end
            end else begin
              ev = 1'b1; ek = K_PROPERTY; again = 1'b1;
            end
          end
          M_COLON: begin
            if (alpha) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              lex_mode_next = M_MSG;
            end else if (c == CH_EQ) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              ev = 1'b1; ek = K_COLON_EQ;
            end else begin
              ev = 1'b1; ek = K_COLON; again = 1'b1;
            end
          end
          M_MSG: begin
            if (word || sfx) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              if (sfx) lex_mode_next = M_MSG_SFX;
            end else begin
              ev = 1'b1; ek = K_MESSAGE; again = 1'b1;
            end
          end
          M_MSG_SFX: begin
            if (sfx) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              ev = 1'b1; ek = K_MESSAGE;
            end else begin
              ev = 1'b1; ek = K_MESSAGE; again = 1'b1;
            end
          end
          M_MINUS: begin
            if (c == CH_GT) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              ev = 1'b1; ek = K_ARROW;
            end else begin
              ev = 1'b1; ek = K_MINUS; again = 1'b1;
            end
          end
          M_EQUAL: begin
            if (c == CH_EQ || c == CH_GT) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              ev = 1'b1; ek = (c == CH_EQ) ? K_EQ_EQ : K_FAT_ARROW;
            end else begin
              ev = 1'b1; ek = K_EQUAL; again = 1'b1;
            end
          end
          M_LESS: begin
            if (c == CH_EQ || c == CH_LT) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              ev = 1'b1; ek = (c == CH_EQ) ? K_LESS_EQ : K_LESS_LESS;
            end else begin
              ev = 1'b1; ek = K_LESS; again = 1'b1;
            end
          end
          M_GREATER: begin
            if (c == CH_EQ || c == CH_GT) begin
              if (token_len_next != '1) token_len_next = token_len_next + 1'b1;
              ev = 1'b1; ek = (c == CH_EQ) ? K_GREATER_EQ : K_GREATER_GREATER;
            end else begin
              ev = 1'b1; ek = K_GREATER; again = 1'b1;
            end
          end
          default: begin
            lex_mode_next = M_IDLE;
            if (endc) begin
              token_len_next = '0;
              if (row_count_next != '1) row_count_next = row_count_next + 32'd1;
              ev = 1'b1; ek = K_EOF; post_restart = 1'b1;
            end else if (c == comment_char) begin
              if (c != CH_LF) lex_mode_next = M_COMMENT;
            end else if (!blank) begin
              token_len_next = LENGTH_BITS'(1);
              if (c == CH_LF) begin
                if (row_count_next != '1) row_count_next = row_count_next + 32'd1;
                ev = 1'b1; ek = K_NEWLINE;
              end else if (alpha) begin
                lex_mode_next = M_IDENT;
                keyword_buffer_next = KB'(c);
              end else if (digit) begin
                lex_mode_next = M_NUM_INT;
              end else if (c == CH_DQUOTE) begin
                lex_mode_next = M_STR_DQ;
              end else if (c == CH_SQUOTE) begin
                lex_mode_next = M_STR_SQ;
                brace_str_next = 1'b0;
              end else if (c == CH_RBRACE && curly_depth_next == 8'd1) begin
                // closing brace of an interpolation resumes the string
                curly_depth_next = 8'd0;
                lex_mode_next = M_STR_SQ;
                brace_str_next = 1'b1;
              end else begin
                ev = 1'b1;
                unique case (c)
                  CH_PLUS:   ek = K_PLUS;
                  CH_STAR:   ek = K_STAR;
                  CH_SLASH:  ek = K_SLASH;
                  CH_PCT:    ek = K_PERCENT;
                  CH_LBRACK: ek = K_LBRACKET;
                  CH_RBRACK: ek = K_RBRACKET;
                  CH_LPAREN: ek = K_LPAREN;
                  CH_RPAREN: ek = K_RPAREN;
                  CH_COMMA:  ek = K_COMMA;
                  CH_SEMI:   ek = K_NEWLINE;
                  CH_PIPE:   ek = K_PIPE;
                  CH_QMARK:  ek = K_QUESTION;
                  CH_AMP:    ek = K_AMPER;
                  CH_BANG:   ek = K_BANG;
                  CH_LBRACE: begin
                    ek = K_LBRACE;
                    if (curly_depth_next != 8'd0 && curly_depth_next != 8'hff)
                      curly_depth_next = curly_depth_next + 8'd1;
                  end
                  CH_RBRACE: begin
                    ek = K_RBRACE;
                    if (curly_depth_next != 8'd0) curly_depth_next = curly_depth_next - 8'd1;
                  end
                  CH_AT:    begin ev = 1'b0; lex_mode_next = M_AT; end
                  CH_DOT:   begin ev = 1'b0; lex_mode_next = M_DOT; end
                  CH_MINUS: begin ev = 1'b0; lex_mode_next = M_MINUS; end
                  CH_COLON: begin ev = 1'b0; lex_mode_next = M_COLON; end
                  CH_EQ:    begin ev = 1'b0; lex_mode_next = M_EQUAL; end
                  CH_LT:    begin ev = 1'b0; lex_mode_next = M_LESS; end
                  CH_GT:    begin ev = 1'b0; lex_mode_next = M_GREATER; end
                  default: begin ek = K_ERROR; ee = E_TOKEN; end
                endcase
              end
            end
          end
        endcase

        if (ev) begin
          if (run.cnt != 2'd3) begin
            run.tok[run.cnt] = '{kind: ek, len: 16'(token_len_next),
                                 line: row_count_next, err: ee};
            run.cnt = run.cnt + 2'd1;
          end
          lex_mode_next = M_IDLE;
        end
        if (post_dot) begin
          token_len_next = LENGTH_BITS'(1);
          lex_mode_next  = M_DOT;
        end
        if (post_restart) begin
          lex_mode_next       = M_IDLE;
          curly_depth_next    = 8'd0;
          row_count_next      = 32'd1;
          token_len_next      = '0;
          keyword_buffer_next = '0;
          brace_str_next      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_char   <= 8'd35;
      lex_mode       <= M_IDLE;
      curly_depth    <= 8'd0;
      row_count      <= 32'd1;
      token_len      <= '0;
      keyword_buffer <= '0;
      brace_str      <= 1'b0;
    end else begin
      if (cfg_we) comment_char <= cfg_data;
      if (accept) begin
        lex_mode       <= lex_mode_next;
        curly_depth    <= curly_depth_next;
        row_count      <= row_count_next;
        token_len      <= token_len_next;
        keyword_buffer <= keyword_buffer_next;
        brace_str      <= brace_str_next;
      end
    end
  end

endmodule

### hw/rtl/stl_queue.sv
// ----------------------------------------------------------------------------
// stl_queue
// Two-entry queue of token runs between the lexing front and the output side.
// ----------------------------------------------------------------------------
module stl_queue import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  run_t       push_run,
  input  logic       pop,
  output logic       full,
  output logic       empty,
  output logic [1:0] count,
  output run_t       head
);

  run_t       entries [2];
  logic       wr_ptr, rd_ptr;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hw/rtl/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back
// Unpacks queued token runs into one registered token per transaction.
// ----------------------------------------------------------------------------
module stl_back import stl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  run_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  token_kind,
  output logic [15:0] token_length,
  output logic [31:0] line_number,
  output logic [1:0]  error_kind,
  output logic        last_of_run
);

  logic [1:0] idx;
  logic       load, last;

  assign load = !empty && (!out_valid || out_ready);
  assign last = idx == head.cnt - 2'd1;
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind   <= head.tok[idx].kind;
      token_length <= head.tok[idx].len;
      line_number  <= head.tok[idx].line;
      error_kind   <= head.tok[idx].err;
      last_of_run  <= last;
    end
  end

endmodule

### hw/rtl/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming lexer: one source byte in, zero to three tokens out.
// ----------------------------------------------------------------------------
// A source byte is taken every cycle while the two-entry token queue has room;
// all tokens a byte closes are found in that same cycle. Tokens leave one per
// cycle from a registered output stage while out_ready is high, and bytes keep
// flowing as long as the average token count per byte stays at or below one.
// The comment character is written through cfg_we/cfg_data and resets to '#'.
module script_token_lexer import stl_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  src_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  token_kind,
  output logic [15:0] token_length,
  output logic [31:0] line_number,
  output logic [1:0]  error_kind,
  output logic        last_of_run
);

  logic       q_full, q_empty, push, pop;
  logic [1:0] q_count;
  run_t       push_run, head;

  stl_front #(.KEYWORD_CHARS(KEYWORD_CHARS), .LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_ready, .src_byte,
    .q_full, .push, .push_run
  );

  stl_queue u_queue (
    .clk, .rst, .push, .push_run, .pop, .full(q_full), .empty(q_empty),
    .count(q_count), .head
  );

  stl_back u_back (
    .clk, .rst, .empty(q_empty), .head, .pop, .out_valid, .out_ready,
    .token_kind, .token_length, .line_number, .error_kind, .last_of_run
  );

  // end of input always closes the run of its byte
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == K_EOF |-> last_of_run)
    else $error("eof token not last of run");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_kind != E_NONE |-> token_kind == K_ERROR)
    else $error("error code on non-error token");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count == 2'd2 |=> !(q_count == 2'd3))
    else $error("token queue overflow");

endmodule

### verif/script_token_lexer_tb.sv
// ----------------------------------------------------------------------------
// script_token_lexer_tb
// Drives source bytes into the lexer and compares every token it emits with
// a cycle-free model of the lexer kept inside the bench.
// ----------------------------------------------------------------------------
module script_token_lexer_tb;
  import stl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KW_CHARS = 6;
  localparam int WATCHDOG = 20000;

  typedef enum int {
    S_IDLE, S_COMMENT, S_IDENT, S_NUM_INT, S_NUM_DOT, S_NUM_FRAC, S_STR_DQ, S_STR_SQ,
    S_AT, S_IMPL, S_DOT, S_PROP, S_COLON, S_MSG, S_MSG_SFX, S_MINUS, S_EQUAL,
    S_LESS, S_GREATER
  } lex_state_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] len;
    logic [31:0] line;
    logic [1:0]  err;
    logic        last;
  } token_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [7:0] cfg_data = 0;
  logic in_valid = 0, out_ready = 0;
  logic [7:0] src_byte = 0;
  logic in_ready, out_valid, last_of_run;
  logic [5:0] token_kind;
  logic [15:0] token_length;
  logic [31:0] line_number;
  logic [1:0] error_kind;

  script_token_lexer dut (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_ready, .src_byte,
    .out_valid, .out_ready, .token_kind, .token_length, .line_number,
    .error_kind, .last_of_run
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // lexer model state
  lex_state_t lx_mode;
  logic [7:0] lx_comment;
  logic [7:0] lx_depth;
  logic [31:0] lx_row;
  logic [15:0] lx_len;
  logic [47:0] lx_kwbuf;
  logic lx_resumed;
  token_t run_toks[$];

  token_t expected_tokens[$];
  int mismatches = 0;
  int stall_left = 0;
  int quiet = 0;
  bit out_idle_on = 1;

  function automatic bit letter_chr(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic bit digit_chr(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_end(logic [7:0] c);
    return c == 8'h00 || c == 8'hff;
  endfunction

  function automatic void lx_restart();
    lx_mode = S_IDLE; lx_depth = 0; lx_row = 1; lx_len = 0; lx_kwbuf = 0;
    lx_resumed = 0;
  endfunction

  function automatic void bump_len();
    if (lx_len != 16'hffff) lx_len++;
  endfunction

  function automatic void push_token(logic [5:0] k, logic [1:0] e);
    token_t t;
    if (run_toks.size() < 3) begin
      t.kind = k; t.len = lx_len; t.line = lx_row; t.err = e; t.last = 0;
      run_toks.push_back(t);
    end
    lx_mode = S_IDLE;
  endfunction

  function automatic logic [5:0] keyword_of();
    string words[18] = '{"and", "do", "def", "else", "end", "false", "match", "for",
      "then", "in", "not", "or", "return", "yield", "true", "nil", "loop", "until"};
    bit same;
    for (int i = 0; i < 18; i++) begin
      if (lx_len != words[i].len() || words[i].len() > KW_CHARS) continue;
      same = 1;
      for (int j = 0; j < words[i].len(); j++)
        if (lx_kwbuf[8*j +: 8] != words[i][j]) same = 0;
      if (same) return 6'(i);
    end
    return K_IDENT;
  endfunction

  function automatic bit idle_byte(logic [7:0] c);
    if (is_end(c)) begin
      lx_len = 0;
      if (lx_row != '1) lx_row++;
      push_token(K_EOF, E_NONE);
      lx_restart();
      return 1;
    end
    if (c == lx_comment) begin
      if (c != CH_LF) lx_mode = S_COMMENT;
      return 1;
    end
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR) return 1;
    lx_len = 1;
    if (c == CH_LF) begin
      if (lx_row != '1) lx_row++;
      push_token(K_NEWLINE, E_NONE);
    end else if (letter_chr(c)) begin
      lx_mode = S_IDENT; lx_kwbuf = 48'(c);
    end else if (digit_chr(c)) lx_mode = S_NUM_INT;
    else if (c == CH_DQUOTE) lx_mode = S_STR_DQ;
    else if (c == CH_SQUOTE) begin
      lx_mode = S_STR_SQ; lx_resumed = 0;
    end else if (c == CH_RBRACE && lx_depth == 1) begin
      lx_depth = 0; lx_mode = S_STR_SQ; lx_resumed = 1;
    end else begin
      case (c)
        CH_PLUS:   push_token(K_PLUS, E_NONE);
        CH_STAR:   push_token(K_STAR, E_NONE);
        CH_SLASH:  push_token(K_SLASH, E_NONE);
        CH_PCT:    push_token(K_PERCENT, E_NONE);
        CH_LBRACK: push_token(K_LBRACKET, E_NONE);
        CH_RBRACK: push_token(K_RBRACKET, E_NONE);
        CH_LPAREN: push_token(K_LPAREN, E_NONE);
        CH_RPAREN: push_token(K_RPAREN, E_NONE);
        CH_COMMA:  push_token(K_COMMA, E_NONE);
        CH_SEMI:   push_token(K_NEWLINE, E_NONE);
        CH_PIPE:   push_token(K_PIPE, E_NONE);
        CH_QMARK:  push_token(K_QUESTION, E_NONE);
        CH_AMP:    push_token(K_AMPER, E_NONE);
        CH_BANG:   push_token(K_BANG, E_NONE);
        CH_LBRACE: begin
          if (lx_depth > 0 && lx_depth != 8'hff) lx_depth++;
          push_token(K_LBRACE, E_NONE);
        end
        CH_RBRACE: begin
          if (lx_depth > 0) lx_depth--;
          push_token(K_RBRACE, E_NONE);
        end
        CH_AT:    lx_mode = S_AT;
        CH_DOT:   lx_mode = S_DOT;
        CH_MINUS: lx_mode = S_MINUS;
        CH_COLON: lx_mode = S_COLON;
        CH_EQ:    lx_mode = S_EQUAL;
        CH_LT:    lx_mode = S_LESS;
        CH_GT:    lx_mode = S_GREATER;
        default:  push_token(K_ERROR, E_TOKEN);
      endcase
    end
    return 1;
  endfunction

  function automatic bit pair_close(logic [7:0] c, logic [7:0] a, logic [5:0] ka,
                                    logic [7:0] b, logic [5:0] kb, logic [5:0] kdef);
    if (c == a) begin
      bump_len(); push_token(ka, E_NONE); return 1;
    end
    if (b != 0 && c == b) begin
      bump_len(); push_token(kb, E_NONE); return 1;
    end
    push_token(kdef, E_NONE);
    return 0;
  endfunction

  // false means the byte is lexed again from the new mode, idle except after a number's dot
  function automatic bit lex_pass(logic [7:0] c);
    bit sfx = (c == CH_QMARK || c == CH_BANG);
    bit word = letter_chr(c) || digit_chr(c);
    case (lx_mode)
      S_COMMENT: begin
        if (is_end(c)) begin
          lx_mode = S_IDLE; return 0;
        end
        if (c == CH_LF) lx_mode = S_IDLE;
        return 1;
      end
      S_IDENT: begin
        if (word) begin
          if (lx_len < KW_CHARS) lx_kwbuf[8*lx_len +: 8] = c;
          bump_len(); return 1;
        end
        if (sfx) begin
          bump_len(); push_token(K_IDENT, E_NONE); return 1;
        end
        push_token(keyword_of(), E_NONE);
        return 0;
      end
      S_NUM_INT: begin
        if (digit_chr(c)) begin
          bump_len(); return 1;
        end
        if (c == CH_DOT) begin
          lx_mode = S_NUM_DOT; return 1;
        end
        push_token(K_NUMBER, E_NONE);
        return 0;
      end
      S_NUM_DOT: begin
        if (digit_chr(c)) begin
          bump_len(); bump_len(); lx_mode = S_NUM_FRAC; return 1;
        end
        push_token(K_NUMBER, E_NONE);
        lx_len = 1; lx_mode = S_DOT;
        return 0;
      end
      S_NUM_FRAC, S_IMPL: begin
        if (digit_chr(c)) begin
          bump_len(); return 1;
        end
        push_token(lx_mode == S_IMPL ? K_IMPLICIT : K_NUMBER, E_NONE);
        return 0;
      end
      S_STR_DQ: begin
        if (is_end(c)) begin
          push_token(K_ERROR, E_STRING); return 0;
        end
        bump_len();
        if (c == CH_DQUOTE) push_token(K_STRING, E_NONE);
        return 1;
      end
      S_STR_SQ: begin
        if (is_end(c) || c == CH_LF) begin
          push_token(K_ERROR, E_STRING); return 0;
        end
        bump_len();
        if (c == CH_LBRACE) begin
          if (lx_depth != 8'hff) lx_depth++;
          push_token(K_INTERP, E_NONE);
        end else if (c == CH_SQUOTE)
          push_token(lx_resumed ? K_INTERP_END : K_STRING, E_NONE);
        return 1;
      end
      S_AT: begin
        if (digit_chr(c)) begin
          bump_len(); lx_mode = S_IMPL; return 1;
        end
        push_token(K_AT, E_NONE);
        return 0;
      end
      S_DOT: begin
        if (letter_chr(c)) begin
          bump_len(); lx_mode = S_PROP; return 1;
        end
        return pair_close(c, CH_DOT, K_DOTDOT, 0, 0, K_DOT);
      end
      S_PROP: begin
        if (word) begin
          bump_len(); return 1;
        end
        if (sfx) begin
          bump_len(); push_token(K_PROPERTY, E_NONE); return 1;
        end
        push_token(K_PROPERTY, E_NONE);
        return 0;
      end
      S_COLON: begin
        if (letter_chr(c)) begin
          bump_len(); lx_mode = S_MSG; return 1;
        end
        return pair_close(c, CH_EQ, K_COLON_EQ, 0, 0, K_COLON);
      end
      S_MSG: begin
        if (word) begin
          bump_len(); return 1;
        end
        if (sfx) begin
          bump_len(); lx_mode = S_MSG_SFX; return 1;
        end
        push_token(K_MESSAGE, E_NONE);
        return 0;
      end
      S_MSG_SFX: begin
        if (sfx) begin
          bump_len(); push_token(K_MESSAGE, E_NONE); return 1;
        end
        push_token(K_MESSAGE, E_NONE);
        return 0;
      end
      S_MINUS:   return pair_close(c, CH_GT, K_ARROW, 0, 0, K_MINUS);
      S_EQUAL:   return pair_close(c, CH_EQ, K_EQ_EQ, CH_GT, K_FAT_ARROW, K_EQUAL);
      S_LESS:    return pair_close(c, CH_EQ, K_LESS_EQ, CH_LT, K_LESS_LESS, K_LESS);
      S_GREATER: return pair_close(c, CH_EQ, K_GREATER_EQ, CH_GT, K_GREATER_GREATER,
                                   K_GREATER);
      default: begin
        lx_mode = S_IDLE;
        return idle_byte(c);
      end
    endcase
  endfunction

  task automatic lex_byte(logic [7:0] c);
    run_toks.delete();
    for (int i = 0; i < 4; i++)
      if (lex_pass(c)) break;
    if (run_toks.size() > 0) run_toks[run_toks.size() - 1].last = 1;
    foreach (run_toks[i]) expected_tokens.push_back(run_toks[i]);
  endtask

  // output side: compare each token transaction and randomize back-pressure
  always @(posedge clk) begin
    token_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{token_kind, token_length, line_number, error_kind, last_of_run};
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token %p", got);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("token mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 0;
    end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17);
      out_ready <= 0;
    end else out_ready <= 1;
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else if (quiet == WATCHDOG) begin
      $display("FAILED: results differ");
      $finish;
    end else quiet <= quiet + 1;
  end

  bit in_idle_on = 1;

  // called at a falling edge; valid stays up between back to back bytes
  task automatic send_byte(logic [7:0] c);
    if (in_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    src_byte <= c;
    in_valid <= 1;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    lex_byte(c);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain_tokens();
    in_valid <= 0;
    while (expected_tokens.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_comment_char(logic [7:0] v);
    drain_tokens();
    cfg_data <= v; cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    lx_comment = v;
  endtask

  // directed rows; expected first token kind given where obvious, -1 = model only
  typedef struct {
    logic [7:0] b;
    int         kind;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{8'h00, K_EOF}, '{8'hff, K_EOF}, '{"+", K_PLUS}, '{8'h01, K_ERROR},
    '{8'h80, K_ERROR}, '{"\n", K_NEWLINE}, '{";", K_NEWLINE}, '{"1", -1},
    '{".", -1}, '{"+", -1}, '{"'", -1}, '{"{", -1}, '{"}", -1}, '{"'", -1},
    '{"\"", -1}, '{8'h00, -1}, '{":", -1}, '{"a", -1}, '{"?", -1}, '{"!", -1},
    '{"@", -1}, '{"7", -1}, '{" ", -1}, '{"#", -1}, '{8'hff, -1}
  };

  string fragments[] = '{
    "return ", "until ", "and ", "do", "def ", "else", "end\n", "false ", "match ",
    "for ", "then ", "in ", "not ", "or ", "yield ", "true ", "nil ", "loop ",
    "returns ", "x? ", "y! ", "foo_9 ", "12.5 ", "3. ", "1..4 ", "@ ", "@12 ",
    ".name ", ".p? ", ".. ", ": ", ":= ", ":m?! ", ":msg ", "-> ", "- ", "=> ",
    "== ", "= ", "<= ", "<< ", "< ", ">= ", ">> ", "> ", "\"a\nb\" ", "'x{y}z' ",
    "'a{ {1} }b' ", "'q\n", "\"open", "# note\n", "{ } ", "[ ] ( ) , | & % * / ",
    "\t\r \n", ";", "ab$ ", "'}' ", "} "
  };

  initial begin
    int count;
    string frag;
    lx_comment = "#";
    lx_restart();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    for (int i = 0; i < dir_rows.size(); i++) begin
      send_byte(dir_rows[i].b);
      if (dir_rows[i].kind >= 0 &&
          (run_toks.size() == 0 || run_toks[0].kind != 6'(dir_rows[i].kind))) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d: kind %0d not predicted", i,
                                       dir_rows[i].kind);
      end
    end

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: set_comment_char(8'h00);
        2: set_comment_char(8'hff);
        3: set_comment_char(CH_LF);
        4: set_comment_char(8'($urandom_range(0, 255)));
        default: ;
      endcase
      if (phase == 4) begin
        in_idle_on = 0;
        out_idle_on = 0;
      end
      count = 0;
      while (count < 85) begin
        if ($urandom_range(0, 9) < 8) begin
          frag = fragments[$urandom_range(0, fragments.size() - 1)];
          send_text(frag);
          count += frag.len();
        end else begin
          send_byte(8'($urandom_range(0, 255)));
          count++;
        end
      end
      send_byte(8'h00);
    end
    set_comment_char("#");
    send_text("a # c\n");
    drain_tokens();

    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
